// ===== rtl/tlv_field_decoder_defines.svh =====
// Assertion macros shared by the tlv field decoder RTL.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef TLV_FIELD_DECODER_DEFINES_SVH
`define TLV_FIELD_DECODER_DEFINES_SVH

// Check a property on every clock edge out of reset.
`define TLV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another on the next clock.
`define TLV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tlvfd_pkg.sv =====
// Package for the tlv field decoder: result codes, phases and the result word type.
// Used by tlv_field_decoder; no dependencies.
package tlvfd_pkg;

	localparam int ID_BITS     = 16;
	localparam int BYTE_BITS   = 8;
	localparam int FIELD_BITS  = 16;
	localparam int HDR_BYTES   = 4;
	// Width of the blob epoch stored per id slot
	localparam int EPOCH_BITS  = 8;

	typedef logic [1:0] hcount_t;
	typedef logic [EPOCH_BITS-1:0] epoch_t;

	localparam hcount_t HDR_ID_LAST = 2'd1;
	localparam hcount_t HDR_LAST    = hcount_t'(HDR_BYTES - 1);
	localparam epoch_t  EPOCH_FIRST = epoch_t'(1);
	localparam epoch_t  EPOCH_LAST  = '1;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_BODY   = 2'd1,
		KIND_END    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_TRUNC_HEADER = 2'd1,
		ST_TRUNC_BODY   = 2'd2,
		ST_DUPLICATE    = 2'd3
	} status_t;

	typedef enum logic {
		PH_HEADER = 1'b0,
		PH_BODY   = 1'b1
	} phase_t;

	typedef struct packed {
		kind_t                 kind;
		logic [FIELD_BITS-1:0] record_id;
		logic [FIELD_BITS-1:0] field_length;
		logic [BYTE_BITS-1:0]  body_byte;
		logic                  last_of_field;
		status_t               status;
	} res_t;

endpackage

// ===== rtl/tlv_field_decoder.sv =====
// Top level of the tlv field decoder: header/body parsing, seen-id store, output skid.
// Depends on tlvfd_pkg, tlvfd_ram and tlv_field_decoder_defines.svh.
//
// Takes one blob byte (or the end marker) per cycle while in_ready is high and gives
// at most one word per byte: a field header once four header bytes are in, each body
// byte with a last flag, and one status word per end marker. Each word is registered
// into the output buffer as its byte is taken. Results leave through a two-entry output
// buffer, so the input keeps flowing while one word waits to be taken. Repeated ids
// are found in a RAM of 2**ID_BITS entries that holds the blob number (epoch) in
// which each id was last seen; the lookup is issued with the second header byte and
// compared with the fourth. After reset, and after every 255th end marker when the
// epoch wraps, the RAM is swept clear one entry per cycle, and in_ready stays low
// while that sweep runs.
`include "tlv_field_decoder_defines.svh"

module tlv_field_decoder #(
	parameter int ID_BITS = tlvfd_pkg::ID_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] record_id,
	output logic [15:0] field_length,
	output logic [7:0]  body_byte,
	output logic        last_of_field,
	output logic [1:0]  status
);

	localparam int DEPTH = 1 << ID_BITS;
	localparam int FB    = tlvfd_pkg::FIELD_BITS;
	localparam int BB    = tlvfd_pkg::BYTE_BITS;

	// Decoder state
	tlvfd_pkg::phase_t  phase_q, phase_d;
	tlvfd_pkg::hcount_t header_count_q, header_count_d;
	logic [FB-1:0]      current_id_q, current_id_d;
	logic [FB-1:0]      remaining_len_q, remaining_len_d;
	logic               pending_dup_q, pending_dup_d;
	tlvfd_pkg::status_t error_q, error_d;

	// Seen-id store control
	tlvfd_pkg::epoch_t  epoch_q;
	logic               clr_active_q;
	logic [ID_BITS-1:0] clr_addr_q;
	tlvfd_pkg::epoch_t  ram_rd_data;
	logic               ram_rd_en;
	logic               hdr_write;
	logic               ram_wr_en;
	logic [ID_BITS-1:0] ram_wr_addr;
	tlvfd_pkg::epoch_t  ram_wr_data;

	// Output buffer
	tlvfd_pkg::res_t    out_q, skid_q, res_d;
	logic               out_valid_q, skid_valid_q;
	logic               has_res;

	logic               acc;
	logic               pop;
	logic               end_blob;
	logic               seen;
	logic [FB-1:0]      id_shift;
	logic [FB-1:0]      len_shift;
	logic [FB-1:0]      rem_dec;

	assign in_ready = !skid_valid_q && !clr_active_q;
	assign acc      = in_valid && in_ready;
	assign pop      = out_valid_q && out_ready;
	assign end_blob = acc && op;

	assign id_shift  = {current_id_q[FB-BB-1:0], data_byte};
	assign len_shift = {remaining_len_q[FB-BB-1:0], data_byte};
	assign rem_dec   = remaining_len_q - FB'(1);
	assign seen      = (ram_rd_data == epoch_q);

	// Decode one word: next state and the result it gives
	always_comb begin
		phase_d         = phase_q;
		header_count_d  = header_count_q;
		current_id_d    = current_id_q;
		remaining_len_d = remaining_len_q;
		pending_dup_d   = pending_dup_q;
		error_d         = error_q;
		ram_rd_en       = 1'b0;
		hdr_write       = 1'b0;
		res_d           = '0;
		has_res         = 1'b0;
		if (acc) begin
			if (op) begin
				res_d.kind = tlvfd_pkg::KIND_END;
				if (error_q != tlvfd_pkg::ST_OK) begin
					res_d.status = error_q;
				end else if (phase_q == tlvfd_pkg::PH_BODY) begin
					res_d.status = tlvfd_pkg::ST_TRUNC_BODY;
				end else if (header_count_q != '0) begin
					res_d.status = tlvfd_pkg::ST_TRUNC_HEADER;
				end else begin
					res_d.status = tlvfd_pkg::ST_OK;
				end
				has_res         = 1'b1;
				phase_d         = tlvfd_pkg::PH_HEADER;
				header_count_d  = '0;
				current_id_d    = '0;
				remaining_len_d = '0;
				pending_dup_d   = 1'b0;
				error_d         = tlvfd_pkg::ST_OK;
			end else if (error_q == tlvfd_pkg::ST_OK) begin
				case (phase_q)
					tlvfd_pkg::PH_HEADER: begin
						header_count_d = header_count_q + 2'd1;
						if (header_count_q <= tlvfd_pkg::HDR_ID_LAST) begin
							current_id_d = id_shift;
						end else begin
							remaining_len_d = len_shift;
						end
						// id is complete: look it up in the seen store
						if (header_count_q == tlvfd_pkg::HDR_ID_LAST) begin
							ram_rd_en = 1'b1;
						end
						if (header_count_q == tlvfd_pkg::HDR_LAST) begin
							header_count_d     = '0;
							hdr_write          = 1'b1;
							has_res            = 1'b1;
							res_d.kind         = tlvfd_pkg::KIND_HEADER;
							res_d.record_id    = current_id_q;
							res_d.field_length = len_shift;
							if (len_shift == '0) begin
								if (seen) begin
									error_d = tlvfd_pkg::ST_DUPLICATE;
								end
								pending_dup_d = 1'b0;
								current_id_d  = '0;
							end else begin
								pending_dup_d = pending_dup_q || seen;
								phase_d       = tlvfd_pkg::PH_BODY;
							end
						end
					end
					tlvfd_pkg::PH_BODY: begin
						remaining_len_d     = rem_dec;
						has_res             = 1'b1;
						res_d.kind          = tlvfd_pkg::KIND_BODY;
						res_d.record_id     = current_id_q;
						res_d.body_byte     = data_byte;
						res_d.last_of_field = (rem_dec == '0);
						if (rem_dec == '0) begin
							if (pending_dup_q) begin
								error_d = tlvfd_pkg::ST_DUPLICATE;
							end
							pending_dup_d = 1'b0;
							phase_d       = tlvfd_pkg::PH_HEADER;
							current_id_d  = '0;
						end
					end
					default: begin
						phase_d = tlvfd_pkg::PH_HEADER;
					end
				endcase
			end
		end
	end

	// Hold decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= tlvfd_pkg::PH_HEADER;
			header_count_q  <= '0;
			current_id_q    <= '0;
			remaining_len_q <= '0;
			pending_dup_q   <= 1'b0;
			error_q         <= tlvfd_pkg::ST_OK;
		end else begin
			phase_q         <= phase_d;
			header_count_q  <= header_count_d;
			current_id_q    <= current_id_d;
			remaining_len_q <= remaining_len_d;
			pending_dup_q   <= pending_dup_d;
			error_q         <= error_d;
		end
	end

	// Advance the blob epoch; sweep the store clear after reset and on wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q      <= tlvfd_pkg::EPOCH_FIRST;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + ID_BITS'(1);
			if (clr_addr_q == '1) begin
				clr_active_q <= 1'b0;
			end
		end else if (end_blob) begin
			if (epoch_q == tlvfd_pkg::EPOCH_LAST) begin
				epoch_q      <= tlvfd_pkg::EPOCH_FIRST;
				clr_active_q <= 1'b1;
				clr_addr_q   <= '0;
			end else begin
				epoch_q <= epoch_q + tlvfd_pkg::EPOCH_FIRST;
			end
		end
	end

	assign ram_wr_en   = clr_active_q || hdr_write;
	assign ram_wr_addr = clr_active_q ? clr_addr_q : current_id_q[ID_BITS-1:0];
	assign ram_wr_data = clr_active_q ? '0 : epoch_q;

	tlvfd_ram #(
		.WIDTH (tlvfd_pkg::EPOCH_BITS),
		.DEPTH (DEPTH)
	) u_seen_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (id_shift[ID_BITS-1:0]),
		.rd_data (ram_rd_data)
	);

	// Output buffer valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (has_res) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output buffer payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (has_res) begin
			if (out_valid_q && !pop) begin
				skid_q <= res_d;
			end else begin
				out_q <= res_d;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_q.kind;
	assign record_id     = out_q.record_id;
	assign field_length  = out_q.field_length;
	assign body_byte     = out_q.body_byte;
	assign last_of_field = out_q.last_of_field;
	assign status        = out_q.status;

	// Checks
	`TLV_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid word without output word")
	`TLV_ASSERT(a_body_has_len, phase_q != tlvfd_pkg::PH_BODY || remaining_len_q != '0, "body phase with zero length left")
	`TLV_ASSERT_NEXT(a_end_resets, end_blob, phase_q == tlvfd_pkg::PH_HEADER && header_count_q == '0 && error_q == tlvfd_pkg::ST_OK, "state not cleared after end marker")
	`TLV_ASSERT_NEXT(a_error_freezes, acc && !op && error_q != tlvfd_pkg::ST_OK, $stable(remaining_len_q) && $stable(phase_q) && !out_valid_q == !$past(out_valid_q && !out_ready) && !$past(has_res), "data byte changed state after error")
	`TLV_ASSERT_NEXT(a_no_write_in_sweep, clr_active_q, !$past(hdr_write), "header store write during clearing sweep")

endmodule

// ===== rtl/tlvfd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used by tlv_field_decoder for the seen-id store; no dependencies.
module tlvfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
